FILE: src/sbst_pkg.sv
`timescale 1ns / 1ps

package sbst_pkg;

   localparam int NUM_AXES  = 3;
   localparam int NUM_PAIRS = 6;

   typedef logic [1:0] axis_idx_type;

   // Every ordered pair of distinct axes: the entry of one against the exit of the other.
   localparam axis_idx_type PAIR_ENTER [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam axis_idx_type PAIR_EXIT  [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

   typedef struct packed {
      logic moving;
      logic static_ok;
   } axis_flag_type;

endpackage

FILE: src/sbst_axis_prep.sv
`timescale 1ns / 1ps

module sbst_axis_prep
   import sbst_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic signed [COORD_BITS-1:0] origin,
   input  logic signed [COORD_BITS-1:0] delta,
   input  logic signed [COORD_BITS-1:0] lo_corner,
   input  logic signed [COORD_BITS-1:0] hi_corner,
   output logic signed [COORD_BITS:0]   enter_num,
   output logic signed [COORD_BITS:0]   exit_num,
   output logic        [COORD_BITS-1:0] den,
   output axis_flag_type                flags
);

   logic signed [COORD_BITS:0] lo_rel;
   logic signed [COORD_BITS:0] hi_rel;
   logic signed [COORD_BITS:0] lo_num;
   logic signed [COORD_BITS:0] hi_num;
   logic                       neg;

   assign lo_rel = {lo_corner[COORD_BITS-1], lo_corner} - {origin[COORD_BITS-1], origin};
   assign hi_rel = {hi_corner[COORD_BITS-1], hi_corner} - {origin[COORD_BITS-1], origin};
   assign neg    = delta[COORD_BITS-1];

   // Fold the sign of the displacement into the numerators so that both
   // parameters share one positive denominator.
   assign lo_num = neg ? -lo_rel : lo_rel;
   assign hi_num = neg ? -hi_rel : hi_rel;
   assign den    = neg ? $unsigned(-delta) : $unsigned(delta);

   always_comb begin
      if (lo_num <= hi_num) begin
         enter_num = lo_num;
         exit_num  = hi_num;
      end else begin
         enter_num = hi_num;
         exit_num  = lo_num;
      end
   end

   assign flags.moving    = (delta != '0);
   assign flags.static_ok = (origin >= lo_corner) && (origin <= hi_corner);

endmodule

FILE: src/segment_box_slab_test_unit.sv
`timescale 1ns / 1ps

// Segment versus axis-aligned box test by the slab method, exact over rationals.
// Request channel (req_valid/req_ready) carries one segment (origin, delta) and
// one box (lo and hi corners), all signed fixed point; the answer does not
// depend on where the binary point sits. Response channel (rsp_valid/rsp_ready)
// returns one bit, rsp_hit, per request, in request order.
// Pipeline: stage one forms the per-axis entry and exit numerators and the
// positive denominator, stage two computes the twelve cross products between
// axes, stage three compares them and is the output register.
// An accepted request is registered in stage one, then stage two, then the
// output register, where rsp_valid rises; one request is taken every
// cycle while the response side keeps up.
// When the receiver stalls, each stage holds only if the stage after it is full
// and held, so bubbles are squeezed out and req_ready falls only once all three
// stages are occupied. Reset clears every stage valid bit; nothing else needs it.
module segment_box_slab_test_unit
   import sbst_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_origin_x,
   input  logic signed [COORD_BITS-1:0] req_origin_y,
   input  logic signed [COORD_BITS-1:0] req_origin_z,
   input  logic signed [COORD_BITS-1:0] req_delta_x,
   input  logic signed [COORD_BITS-1:0] req_delta_y,
   input  logic signed [COORD_BITS-1:0] req_delta_z,
   input  logic signed [COORD_BITS-1:0] req_lo_corner_x,
   input  logic signed [COORD_BITS-1:0] req_lo_corner_y,
   input  logic signed [COORD_BITS-1:0] req_lo_corner_z,
   input  logic signed [COORD_BITS-1:0] req_hi_corner_x,
   input  logic signed [COORD_BITS-1:0] req_hi_corner_y,
   input  logic signed [COORD_BITS-1:0] req_hi_corner_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit
);

   localparam int PROD_BITS = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] origin_arr [NUM_AXES];
   logic signed [COORD_BITS-1:0] delta_arr  [NUM_AXES];
   logic signed [COORD_BITS-1:0] lo_arr     [NUM_AXES];
   logic signed [COORD_BITS-1:0] hi_arr     [NUM_AXES];

   logic signed [COORD_BITS:0]   enter_in   [NUM_AXES];
   logic signed [COORD_BITS:0]   exit_in    [NUM_AXES];
   logic        [COORD_BITS-1:0] den_in     [NUM_AXES];
   axis_flag_type                flag_in    [NUM_AXES];

   logic signed [COORD_BITS:0]   enter_ff   [NUM_AXES];
   logic signed [COORD_BITS:0]   exit_ff    [NUM_AXES];
   logic        [COORD_BITS-1:0] den_ff     [NUM_AXES];
   axis_flag_type                flag_ff    [NUM_AXES];

   logic signed [PROD_BITS-1:0]  enter_prod_in [NUM_PAIRS];
   logic signed [PROD_BITS-1:0]  exit_prod_in  [NUM_PAIRS];
   logic signed [PROD_BITS-1:0]  enter_prod_ff [NUM_PAIRS];
   logic signed [PROD_BITS-1:0]  exit_prod_ff  [NUM_PAIRS];
   logic [NUM_AXES-1:0]          moving_in;
   logic [NUM_AXES-1:0]          moving_ff;
   logic                         basic_ok_in;
   logic                         basic_ok_ff;

   logic                         hit_in;
   logic                         hit_ff;

   logic                         s1_valid_in, s1_valid_ff;
   logic                         s2_valid_in, s2_valid_ff;
   logic                         rsp_valid_in, rsp_valid_ff;
   logic                         s1_adv, s2_adv, out_adv;

   assign origin_arr = '{req_origin_x, req_origin_y, req_origin_z};
   assign delta_arr  = '{req_delta_x, req_delta_y, req_delta_z};
   assign lo_arr     = '{req_lo_corner_x, req_lo_corner_y, req_lo_corner_z};
   assign hi_arr     = '{req_hi_corner_x, req_hi_corner_y, req_hi_corner_z};

   // ---------------- flow control ----------------
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   always_comb begin
      s1_valid_in  = s1_adv  ? req_valid   : s1_valid_ff;
      s2_valid_in  = s2_adv  ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_adv ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage one: per-axis slab ----------------
   for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
      sbst_axis_prep #(
         .COORD_BITS (COORD_BITS)
      ) u_prep (
         .origin    (origin_arr[k]),
         .delta     (delta_arr[k]),
         .lo_corner (lo_arr[k]),
         .hi_corner (hi_arr[k]),
         .enter_num (enter_in[k]),
         .exit_num  (exit_in[k]),
         .den       (den_in[k]),
         .flags     (flag_in[k])
      );
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         enter_ff <= enter_in;
         exit_ff  <= exit_in;
         den_ff   <= den_in;
         flag_ff  <= flag_in;
      end
   end

   // ---------------- stage two: cross products ----------------
   // Entry of axis i against exit of axis j: e_i/D_i <= x_j/D_j becomes
   // e_i*D_j <= x_j*D_i, both denominators being positive.
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         enter_prod_in[p] = $signed(enter_ff[PAIR_ENTER[p]])
                          * $signed({1'b0, den_ff[PAIR_EXIT[p]]});
         exit_prod_in[p]  = $signed(exit_ff[PAIR_EXIT[p]])
                          * $signed({1'b0, den_ff[PAIR_ENTER[p]]});
      end
   end

   // Checks against the initial interval [0,1], and the origin test on
   // stationary axes.
   always_comb begin
      basic_ok_in = 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
         moving_in[k] = flag_ff[k].moving;
         if (flag_ff[k].moving) begin
            if (enter_ff[k] > $signed({1'b0, den_ff[k]}) || exit_ff[k][COORD_BITS]) begin
               basic_ok_in = 1'b0;
            end
         end else if (!flag_ff[k].static_ok) begin
            basic_ok_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         enter_prod_ff <= enter_prod_in;
         exit_prod_ff  <= exit_prod_in;
         moving_ff     <= moving_in;
         basic_ok_ff   <= basic_ok_in;
      end
   end

   // ---------------- stage three: compare and output ----------------
   always_comb begin
      hit_in = basic_ok_ff;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         if (moving_ff[PAIR_ENTER[p]] && moving_ff[PAIR_EXIT[p]]
             && (enter_prod_ff[p] > exit_prod_ff[p])) begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = hit_ff;

   // ---------------- assertions ----------------
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("pipeline valid bits not cleared by reset");

   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request refused while the pipeline has a free stage");

   a_stage2_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_adv) |=>
         (s2_valid_ff && $stable(basic_ok_ff) && $stable(moving_ff)))
      else $error("stalled stage two lost its contents");

   a_basic_miss : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_adv && !basic_ok_ff) |=> (rsp_valid_ff && !rsp_hit))
      else $error("hit reported although an axis rejected the segment");

endmodule

FILE: dv/tb_segment_box_slab_test_unit.sv
`timescale 1ns / 1ps

module tb_segment_box_slab_test_unit;

   localparam int COORD_W     = 32;
   localparam int RANDOM_LEN  = 530;
   localparam int PHASE_LEN   = 185;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_EVERY = 137;

   typedef logic signed [COORD_W-1:0]    coord_t;
   typedef logic signed [COORD_W+7:0]    span_t;
   typedef logic signed [2*COORD_W+15:0] cross_t;

   localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_t COORD_MIN = ~COORD_MAX;
   localparam coord_t ONE       = coord_t'(65536);
   localparam coord_t HALF      = coord_t'(32768);

   typedef struct packed {
      coord_t origin_x;
      coord_t origin_y;
      coord_t origin_z;
      coord_t delta_x;
      coord_t delta_y;
      coord_t delta_z;
      coord_t lo_x;
      coord_t lo_y;
      coord_t lo_z;
      coord_t hi_x;
      coord_t hi_y;
      coord_t hi_z;
      logic   hold_for_drain;
   } segment_box_t;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_ready;
   coord_t req_origin_x = '0;
   coord_t req_origin_y = '0;
   coord_t req_origin_z = '0;
   coord_t req_delta_x = '0;
   coord_t req_delta_y = '0;
   coord_t req_delta_z = '0;
   coord_t req_lo_corner_x = '0;
   coord_t req_lo_corner_y = '0;
   coord_t req_lo_corner_z = '0;
   coord_t req_hi_corner_x = '0;
   coord_t req_hi_corner_y = '0;
   coord_t req_hi_corner_z = '0;
   logic   rsp_valid;
   logic   rsp_ready = 1'b0;
   logic   rsp_hit;

   segment_box_t pending_queries[$];
   logic         expected_hits[$];
   int           hits_issued = 0;
   int           hits_checked = 0;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           send_idle_pct;
   int           recv_idle_pct;

   segment_box_slab_test_unit #(
      .COORD_BITS(COORD_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_origin_z   (req_origin_z),
      .req_delta_x    (req_delta_x),
      .req_delta_y    (req_delta_y),
      .req_delta_z    (req_delta_z),
      .req_lo_corner_x(req_lo_corner_x),
      .req_lo_corner_y(req_lo_corner_y),
      .req_lo_corner_z(req_lo_corner_z),
      .req_hi_corner_x(req_hi_corner_x),
      .req_hi_corner_y(req_hi_corner_y),
      .req_hi_corner_z(req_hi_corner_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit)
   );

   always #2 clock = ~clock;

   // Orders an/ad against bn/bd; both denominators are positive.
   function automatic int compare_ratio(span_t an, span_t ad, span_t bn, span_t bd);
      cross_t lhs;
      cross_t rhs;
      lhs = cross_t'(an) * cross_t'(bd);
      rhs = cross_t'(bn) * cross_t'(ad);
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic logic segment_meets_box(segment_box_t q);
      coord_t org[3];
      coord_t dlt[3];
      coord_t lo[3];
      coord_t hi[3];
      span_t  enter_n;
      span_t  exit_n;
      span_t  swap_n;
      span_t  den;
      span_t  tmin_n;
      span_t  tmin_d;
      span_t  tmax_n;
      span_t  tmax_d;
      org = '{q.origin_x, q.origin_y, q.origin_z};
      dlt = '{q.delta_x, q.delta_y, q.delta_z};
      lo  = '{q.lo_x, q.lo_y, q.lo_z};
      hi  = '{q.hi_x, q.hi_y, q.hi_z};
      tmin_n = 0;
      tmin_d = 1;
      tmax_n = 1;
      tmax_d = 1;
      for (int k = 0; k < 3; k++) begin
         if (dlt[k] == 0) begin
            if (org[k] < lo[k] || org[k] > hi[k]) return 1'b0;
         end else begin
            if (dlt[k] > 0) begin
               enter_n = span_t'(lo[k]) - span_t'(org[k]);
               exit_n  = span_t'(hi[k]) - span_t'(org[k]);
               den     = span_t'(dlt[k]);
            end else begin
               enter_n = span_t'(org[k]) - span_t'(lo[k]);
               exit_n  = span_t'(org[k]) - span_t'(hi[k]);
               den     = -span_t'(dlt[k]);
            end
            if (compare_ratio(enter_n, den, exit_n, den) > 0) begin
               swap_n  = enter_n;
               enter_n = exit_n;
               exit_n  = swap_n;
            end
            if (compare_ratio(enter_n, den, tmin_n, tmin_d) > 0) begin
               tmin_n = enter_n;
               tmin_d = den;
            end
            if (compare_ratio(exit_n, den, tmax_n, tmax_d) < 0) begin
               tmax_n = exit_n;
               tmax_d = den;
            end
            if (compare_ratio(tmin_n, tmin_d, tmax_n, tmax_d) > 0) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic coord_t clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return coord_t'(v);
   endfunction

   // Most requests aim a segment at a point in or near a random box, so that
   // all three slabs matter; the rest are raw bit patterns.
   function automatic segment_box_t make_query();
      longint lo[3];
      longint hi[3];
      longint org[3];
      longint dlt[3];
      longint span;
      longint aim;
      longint base;
      longint tmp;
      int     reach;
      int     flip;
      coord_t c[12];
      if ($urandom_range(7) == 0) begin
         for (int k = 0; k < 12; k++) c[k] = $urandom;
      end else begin
         reach = $urandom_range(3);
         for (int k = 0; k < 3; k++) begin
            span = longint'(1) << $urandom_range(28);
            base = ($urandom_range(1) == 0) ? 0 : longint'($signed($urandom)) >>> 1;
            lo[k] = base + longint'($urandom_range(32'(2 * span))) - span;
            hi[k] = ($urandom_range(3) == 0) ? lo[k]
                    : lo[k] + longint'($urandom_range(32'(span)));
            case ($urandom_range(7))
               0: aim = lo[k] - 1 - longint'($urandom_range(32'(span / 8)));
               1: aim = hi[k] + 1 + longint'($urandom_range(32'(span / 8)));
               default: aim = lo[k] + longint'($urandom_range(32'(hi[k] - lo[k])));
            endcase
            if ($urandom_range(5) == 0) begin
               org[k] = ($urandom_range(3) == 0) ? aim
                        : lo[k] + longint'($urandom_range(32'(hi[k] - lo[k])));
               dlt[k] = 0;
            end else begin
               org[k] = aim + longint'($urandom_range(32'(4 * span))) - 2 * span;
               // The aim point is reached at t = 1, 1/2 or 1/4, or never.
               case (reach)
                  0: dlt[k] = aim - org[k];
                  1: dlt[k] = (aim - org[k]) * 2;
                  2: dlt[k] = (aim - org[k]) * 4;
                  default: dlt[k] = (aim - org[k]) / 2;
               endcase
               if ($urandom_range(7) == 0) dlt[k] += longint'($urandom_range(2)) - 1;
            end
         end
         if ($urandom_range(15) == 0) begin
            flip = $urandom_range(2);
            tmp = lo[flip];
            lo[flip] = hi[flip];
            hi[flip] = tmp;
         end
         for (int k = 0; k < 3; k++) begin
            c[k]     = clamp_coord(org[k]);
            c[3 + k] = clamp_coord(dlt[k]);
            c[6 + k] = clamp_coord(lo[k]);
            c[9 + k] = clamp_coord(hi[k]);
         end
      end
      return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11],
              1'b0};
   endfunction

   task automatic queue_query(input coord_t ox, oy, oz, dx, dy, dz,
                              input coord_t lx, ly, lz, hx, hy, hz,
                              input logic drain_first = 1'b0);
      pending_queries.insert(pending_queries.size(),
                             {ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz,
                              drain_first});
   endtask

   always_comb begin
      if (hits_issued < PHASE_LEN) begin
         send_idle_pct = 30;
         recv_idle_pct = 60;
      end else if (hits_issued < 2 * PHASE_LEN) begin
         send_idle_pct = 60;
         recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // The expected answer is queued when a request goes onto the bus, so it is
   // always in place before any response to it can be sampled.
   always @(posedge clock) begin : request_driver
      segment_box_t next_query;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_queries[0].hold_for_drain && hits_issued != hits_checked)) begin
            next_query = pending_queries.pop_front();
            req_origin_x    <= next_query.origin_x;
            req_origin_y    <= next_query.origin_y;
            req_origin_z    <= next_query.origin_z;
            req_delta_x     <= next_query.delta_x;
            req_delta_y     <= next_query.delta_y;
            req_delta_z     <= next_query.delta_z;
            req_lo_corner_x <= next_query.lo_x;
            req_lo_corner_y <= next_query.lo_y;
            req_lo_corner_z <= next_query.lo_z;
            req_hi_corner_x <= next_query.hi_x;
            req_hi_corner_y <= next_query.hi_y;
            req_hi_corner_z <= next_query.hi_z;
            req_valid       <= 1'b1;
            expected_hits.insert(expected_hits.size(), segment_meets_box(next_query));
            hits_issued <= hits_issued + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      logic want_hit;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %0b",
                        $time, rsp_hit);
               mismatch_count++;
            end else begin
               want_hit = expected_hits.pop_front();
               hits_checked <= hits_checked + 1;
               if (rsp_hit !== want_hit) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, want_hit, rsp_hit);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      segment_box_t q;
      // Unit box, stationary origin inside, then outside.
      queue_query(HALF, HALF, HALF, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      queue_query(2 * ONE, HALF, HALF, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      // Straight through along x; ending exactly on the face; one step short.
      queue_query(-ONE, HALF, HALF, 3 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      queue_query(-ONE, HALF, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      queue_query(-ONE, HALF, HALF, ONE - 1, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      // Starting on the far face and leaving it.
      queue_query(ONE, HALF, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      // Touching only the corner point.
      queue_query(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE);
      // Sliding along a face, then one step above it.
      queue_query(-ONE, ONE, HALF, 3 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      queue_query(-ONE, ONE + 1, HALF, 3 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      // Negative displacement, issued only once the pipeline has drained.
      queue_query(2 * ONE, HALF, HALF, -3 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE, 1'b1);
      // Inverted box on a moving axis, then on a stationary axis.
      queue_query(-ONE, HALF, HALF, 3 * ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE);
      queue_query(-ONE, HALF, HALF, 3 * ONE, 0, 0, 0, ONE, 0, ONE, 0, ONE);
      // Point-sized box hit at mid-segment.
      queue_query(0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      // Each slab is crossed, but never at the same time.
      queue_query(-ONE, ONE + ONE / 4, HALF, 2 * ONE, -4 * ONE, 0,
                  0, 0, 0, ONE, ONE, ONE);
      // Extremes of the coordinate range.
      queue_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_query(COORD_MIN, 0, 0, COORD_MAX, 0, 0, COORD_MAX, 0, 0, COORD_MAX, 0, 0);
      queue_query(COORD_MAX, 0, 0, COORD_MIN, 0, 0, COORD_MIN, 0, 0, COORD_MIN, 0, 0);
      queue_query(COORD_MAX, 0, 0, COORD_MIN, 0, 0, COORD_MIN, 0, 0, COORD_MAX, 0, 0);
      queue_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, -1, -1, -1);
      queue_query(0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                  COORD_MAX, 0, 0, COORD_MIN, 0, 0);
      queue_query(-1, -1, -1, COORD_MIN, -1, 1, COORD_MIN, COORD_MIN, -1,
                  COORD_MAX, -1, COORD_MAX);
      for (int n = 0; n < RANDOM_LEN; n++) begin
         q = make_query();
         q.hold_for_drain = (n % DRAIN_EVERY == 0);
         pending_queries.insert(pending_queries.size(), q);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_queries.size() != 0 || req_valid || hits_issued != hits_checked)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_hits.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
